[rtl/core/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the envelope block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every rising clock edge outside reset.
`define ARE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("envelope assertion failed");
// Expression must never be true outside reset.
`define ARE_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("envelope forbidden condition seen");
`else
`define ARE_ASSERT(label, clk, rst_n, prop)
`define ARE_NEVER(label, clk, rst_n, expr)
`endif
`endif

[rtl/core/are_pkg.sv]
// Package of the envelope block: widths, phase and sequencer types, register indexes.
`default_nettype none
package are_pkg;
	localparam int unsigned LVL_W  = 8;
	localparam int unsigned PE_W   = 16;
	localparam int unsigned STEP_W = 8;
	localparam int unsigned PROD_W = LVL_W + PE_W;
	localparam int unsigned IDX_W  = 8;

	localparam logic [IDX_W-1:0] CFG_ATTACK_MS  = 8'd0;
	localparam logic [IDX_W-1:0] CFG_RELEASE_MS = 8'd1;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_ATTACK  = 2'd1,
		PH_SUSTAIN = 2'd2,
		PH_RELEASE = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_MUL,
		SEQ_DIV,
		SEQ_OUT
	} seq_t;
endpackage
`default_nettype wire

[rtl/core/are_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
`default_nettype none
module are_mul (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [are_pkg::PE_W-1:0]      a,
	input  wire logic [are_pkg::LVL_W-1:0]     b,
	output logic                               done,
	output logic [are_pkg::PROD_W-1:0]         prod
);
	localparam int unsigned CNT_W = $clog2(are_pkg::LVL_W);

	logic [are_pkg::PROD_W-1:0] acc_q;
	logic [are_pkg::PE_W-1:0]   a_q;
	logic [are_pkg::LVL_W-1:0]  b_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [are_pkg::PROD_W-1:0] acc_nxt;

	always_comb begin
		acc_nxt = {acc_q[are_pkg::PROD_W-2:0], 1'b0};
		if (b_q[are_pkg::LVL_W-1]) begin
			acc_nxt = acc_nxt + are_pkg::PROD_W'(a_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(are_pkg::LVL_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
			b_q   <= {b_q[are_pkg::LVL_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

[rtl/core/are_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module are_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [are_pkg::PROD_W-1:0]    dividend,
	input  wire logic [are_pkg::PE_W-1:0]      divisor,
	output logic                               done,
	output logic [are_pkg::PROD_W-1:0]         quot
);
	localparam int unsigned CNT_W = $clog2(are_pkg::PROD_W);

	logic [are_pkg::PROD_W-1:0] num_q;
	logic [are_pkg::PE_W-1:0]   rem_q;
	logic [are_pkg::PE_W-1:0]   den_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [are_pkg::PE_W:0]     trial;
	logic [are_pkg::PE_W:0]     diff;
	logic                       ge;

	always_comb begin
		trial = {rem_q, num_q[are_pkg::PROD_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(are_pkg::PROD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays below the divisor, so it fits PE_W bits
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[are_pkg::PROD_W-2:0], ge};
			rem_q <= ge ? diff[are_pkg::PE_W-1:0] : trial[are_pkg::PE_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;
endmodule
`default_nettype wire

[rtl/core/attack_release_envelope.sv]
// Top level of the gate-driven linear attack/release envelope generator.
// Each input transfer is one update (gate level, milliseconds since the previous update)
// and yields exactly one output transfer with the new level and phase. The ramp term
// MAX_LEVEL*elapsed/duration is formed by a bit-serial multiplier followed by a
// restoring divider. A new update is taken once the previous one has been committed to
// the output register, even while that result still waits to be taken. Durations of
// zero act as one millisecond; the time in the current phase saturates at 65535 ms.
`default_nettype none
`include "assert_macros.svh"
module attack_release_envelope #(
	parameter int unsigned MAX_LEVEL = 240
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [are_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [are_pkg::PE_W-1:0]      cfg_data,
	// update input
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [15:0]                   s_tdata,  // [0] gate, [8:1] step_ms
	// result output
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [15:0]                        m_tdata   // [7:0] level, [9:8] phase
);
	localparam logic [are_pkg::LVL_W-1:0] MaxLv = are_pkg::LVL_W'(MAX_LEVEL);

	are_pkg::seq_t   seq_q, seq_nxt;
	are_pkg::phase_t phase_q, phase_nxt;

	logic [are_pkg::PE_W-1:0]   attack_ms_q;
	logic [are_pkg::PE_W-1:0]   release_ms_q;
	logic [are_pkg::LVL_W-1:0]  start_q;
	logic [are_pkg::PE_W-1:0]   elapsed_q;
	logic                       gate_q;
	logic                       m_valid_q;
	logic [are_pkg::LVL_W-1:0]  m_level_q;
	are_pkg::phase_t            m_phase_q;

	logic                       in_xfer;
	logic                       out_free;
	logic                       commit;
	logic                       in_gate;
	logic [are_pkg::STEP_W-1:0] in_step;
	logic [are_pkg::PE_W:0]     elapsed_sum;
	logic [are_pkg::PE_W-1:0]   elapsed_sat;
	logic [are_pkg::PE_W-1:0]   dur_sel;
	logic [are_pkg::PE_W-1:0]   divisor;
	logic                       mul_done;
	logic [are_pkg::PROD_W-1:0] prod;
	logic                       div_done;
	logic [are_pkg::PROD_W-1:0] quot;
	logic [are_pkg::LVL_W-1:0]  q_sat;
	logic                       full;
	logic                       empty;
	logic [are_pkg::LVL_W-1:0]  level_nxt;
	logic [are_pkg::LVL_W-1:0]  start_nxt;

	assign cfg_ready = 1'b1;
	assign in_gate   = s_tdata[0];
	assign in_step   = s_tdata[8:1];
	assign s_tready  = (seq_q == are_pkg::SEQ_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;

	always_comb begin
		elapsed_sum = {1'b0, elapsed_q} + are_pkg::PE_W'(in_step);
		elapsed_sat = elapsed_sum[are_pkg::PE_W] ? '1 : elapsed_sum[are_pkg::PE_W-1:0];
		dur_sel     = (phase_q == are_pkg::PH_RELEASE) ? release_ms_q : attack_ms_q;
		divisor     = (dur_sel == '0) ? are_pkg::PE_W'(1) : dur_sel;
	end

	are_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_xfer),
		.a        (elapsed_sat),
		.b        (MaxLv),
		.done     (mul_done),
		.prod     (prod)
	);

	are_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mul_done),
		.dividend (prod),
		.divisor  (divisor),
		.done     (div_done),
		.quot     (quot)
	);

	// Sequencer next state
	always_comb begin
		seq_nxt = seq_q;
		unique case (seq_q)
			are_pkg::SEQ_IDLE: if (in_xfer)  seq_nxt = are_pkg::SEQ_MUL;
			are_pkg::SEQ_MUL:  if (mul_done) seq_nxt = are_pkg::SEQ_DIV;
			are_pkg::SEQ_DIV:  if (div_done) seq_nxt = are_pkg::SEQ_OUT;
			are_pkg::SEQ_OUT:  if (out_free) seq_nxt = are_pkg::SEQ_IDLE;
			default:           seq_nxt = are_pkg::SEQ_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		commit = (seq_q == are_pkg::SEQ_OUT) && out_free;
	end

	// Phase step; quotient saturated to 8 bits is enough for every compare below
	always_comb begin
		q_sat     = (|quot[are_pkg::PROD_W-1:are_pkg::LVL_W]) ? '1 : quot[are_pkg::LVL_W-1:0];
		full      = q_sat >= (MaxLv - start_q);
		empty     = q_sat >= start_q;
		phase_nxt = phase_q;
		start_nxt = start_q;
		level_nxt = '0;
		unique case (phase_q)
			are_pkg::PH_IDLE: begin
				level_nxt = '0;
				if (gate_q) phase_nxt = are_pkg::PH_ATTACK;
			end
			are_pkg::PH_ATTACK: begin
				level_nxt = full ? MaxLv : start_q + q_sat;
				if (!gate_q) begin
					start_nxt = level_nxt;
					phase_nxt = are_pkg::PH_RELEASE;
				end else if (full) begin
					start_nxt = MaxLv;
					phase_nxt = are_pkg::PH_SUSTAIN;
				end
			end
			are_pkg::PH_SUSTAIN: begin
				level_nxt = MaxLv;
				if (!gate_q) begin
					start_nxt = MaxLv;
					phase_nxt = are_pkg::PH_RELEASE;
				end
			end
			are_pkg::PH_RELEASE: begin
				level_nxt = empty ? '0 : start_q - q_sat;
				if (gate_q) begin
					start_nxt = level_nxt;
					phase_nxt = are_pkg::PH_ATTACK;
				end else if (empty) begin
					start_nxt = '0;
					phase_nxt = are_pkg::PH_IDLE;
				end
			end
			default: phase_nxt = are_pkg::PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q        <= are_pkg::SEQ_IDLE;
			phase_q      <= are_pkg::PH_IDLE;
			start_q      <= '0;
			elapsed_q    <= '0;
			attack_ms_q  <= are_pkg::PE_W'(1);
			release_ms_q <= are_pkg::PE_W'(1);
			m_valid_q    <= 1'b0;
		end else begin
			seq_q <= seq_nxt;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == are_pkg::CFG_ATTACK_MS) begin
					attack_ms_q <= cfg_data;
				end else if (cfg_index == are_pkg::CFG_RELEASE_MS) begin
					release_ms_q <= cfg_data;
				end
			end
			if (in_xfer) begin
				elapsed_q <= elapsed_sat;
			end else if (commit && (phase_nxt != phase_q)) begin
				elapsed_q <= '0;
			end
			if (commit) begin
				phase_q   <= phase_nxt;
				start_q   <= start_nxt;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			gate_q <= in_gate;
		end
		if (commit) begin
			m_level_q <= level_nxt;
			m_phase_q <= phase_nxt;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b0, m_phase_q, m_level_q};

	`ARE_ASSERT(a_level_in_range, clk, arst_n, m_tvalid |-> (m_tdata[7:0] <= MaxLv))
	`ARE_ASSERT(a_idle_is_zero, clk, arst_n, (m_tvalid && m_phase_q == are_pkg::PH_IDLE) |-> (m_level_q == '0))
	`ARE_ASSERT(a_sustain_is_full, clk, arst_n, (m_tvalid && m_phase_q == are_pkg::PH_SUSTAIN) |-> (m_level_q == MaxLv))
	`ARE_ASSERT(a_start_in_range, clk, arst_n, start_q <= MaxLv)
	`ARE_NEVER(a_div_done_misplaced, clk, arst_n, div_done && (seq_q != are_pkg::SEQ_DIV))
endmodule
`default_nettype wire
